// File: src/bdsl_pkg.sv
// Shared types and constants for the button debouncer with short/long press detection.
// No dependencies; every other file imports this package.
`default_nettype none

package bdsl_pkg;

   // field widths
   localparam int TimeWidth = 16;
   localparam int AddrWidth = 4;
   localparam int DataWidth = 32;

   // long_time value stored for a zero write and after reset
   localparam logic [TimeWidth-1:0] LONG_DEFAULT = 16'hffff;

   // reset values of the configuration registers
   localparam logic                 REST_RESET     = 1'b1;
   localparam logic [TimeWidth-1:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [TimeWidth-1:0] SHORT_RESET    = 16'd50;

   // debouncer phases
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_FALLING = 2'd1;
   localparam logic [1:0] PH_PRESSED = 2'd2;
   localparam logic [1:0] PH_RISING  = 2'd3;

   // event codes
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_LONG  = 2'd2;

   // item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_REST     = 2'd0;
   localparam logic [1:0] REG_DEBOUNCE = 2'd1;
   localparam logic [1:0] REG_SHORT    = 2'd2;
   localparam logic [1:0] REG_LONG     = 2'd3;

   typedef struct packed {
      logic                 rest_level;
      logic [TimeWidth-1:0] settle_time;
      logic [TimeWidth-1:0] short_time;
      logic [TimeWidth-1:0] long_time;
   } cfg_type;

   typedef struct packed {
      logic                 op;
      logic [TimeWidth-1:0] time_now;
      logic                 pin_level;
   } item_type;

   typedef struct packed {
      logic [1:0] event_code;
      logic [1:0] phase;
   } result_type;

endpackage

`default_nettype wire

// File: src/bdsl_if.sv
// Valid/ready channel interfaces for the debouncer's item and result streams.
// Depends on bdsl_pkg for the field widths.
`default_nettype none

interface bdsl_req_if
   import bdsl_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [TimeWidth-1:0] time_now;
   logic                 pin_level;

   modport source (output valid, output op, output time_now, output pin_level, input ready);
   modport sink   (input valid, input op, input time_now, input pin_level, output ready);
endinterface

interface bdsl_rsp_if
   import bdsl_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [1:0] event_code;
   logic [1:0] phase;

   modport source (output valid, output event_code, output phase, input ready);
   modport sink   (input valid, input event_code, input phase, output ready);
endinterface

`default_nettype wire

// File: src/bdsl_csr.sv
// APB-style configuration registers for the debouncer.
// Depends on bdsl_pkg; feeds the register values to bdsl_core as one struct.
`default_nettype none

module bdsl_csr
   import bdsl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [AddrWidth-1:0] paddr,
   input  wire logic [DataWidth-1:0] pwdata,
   output      logic [DataWidth-1:0] prdata,
   output      logic                 pready,
   output      cfg_type              cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;
   logic [TimeWidth-1:0] wr_time;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[AddrWidth-1:2];
   assign wr_time = pwdata[TimeWidth-1:0];

   // decode the write transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_REST:     cfg_in.rest_level  = pwdata[0];
            REG_DEBOUNCE: cfg_in.settle_time = wr_time;
            REG_SHORT:    cfg_in.short_time  = wr_time;
            REG_LONG:     cfg_in.long_time   = (wr_time == '0) ? LONG_DEFAULT : wr_time;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rest_level  <= REST_RESET;
         cfg_ff.settle_time <= DEBOUNCE_RESET;
         cfg_ff.short_time  <= SHORT_RESET;
         cfg_ff.long_time   <= LONG_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_REST:     prdata[0]            = cfg_ff.rest_level;
         REG_DEBOUNCE: prdata[TimeWidth-1:0] = cfg_ff.settle_time;
         REG_SHORT:    prdata[TimeWidth-1:0] = cfg_ff.short_time;
         REG_LONG:     prdata[TimeWidth-1:0] = cfg_ff.long_time;
         default:      prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

   // long_time never holds zero
   a_long_nonzero: assert property (@(posedge clock) disable iff (reset)
      cfg_ff.long_time != '0)
      else $error("long_time register holds zero");

   // a long_time write of zero stores the default
   a_long_zero_wr: assert property (@(posedge clock) disable iff (reset)
      wr_en && reg_idx == REG_LONG && wr_time == '0 |=> cfg_ff.long_time == LONG_DEFAULT)
      else $error("zero long_time write not mapped to default");

   // no write, no change
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> $stable(cfg_ff))
      else $error("configuration changed without a write transfer");

endmodule

`default_nettype wire

// File: src/bdsl_core.sv
// Debouncer state and next-state logic: four-phase FSM, press timing and event latch.
// Depends on bdsl_pkg; advances once per item when fire is high.
`default_nettype none

module bdsl_core
   import bdsl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output      result_type result
);

   logic [1:0]           phase_ff, phase_in;
   logic [TimeWidth-1:0] mark_ff, mark_in;
   logic [TimeWidth-1:0] saved_ff, saved_in;
   logic                 long_marked_ff, long_marked_in;
   logic                 ev_pending_ff, ev_pending_in;
   logic                 ev_long_ff, ev_long_in;
   logic                 active;
   logic [TimeWidth-1:0] elapsed;
   logic                 deb_done;

   assign active   = item.pin_level != cfg.rest_level;
   assign elapsed  = item.time_now - mark_ff;
   assign deb_done = elapsed >= cfg.settle_time;

   // next state for one item
   always_comb begin
      phase_in       = phase_ff;
      mark_in        = mark_ff;
      saved_in       = saved_ff;
      long_marked_in = long_marked_ff;
      ev_pending_in  = ev_pending_ff;
      ev_long_in     = ev_long_ff;
      if (item.op == OP_CLEAR) begin
         ev_pending_in = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               long_marked_in = 1'b0;
               if (active) begin
                  phase_in = PH_FALLING;
                  mark_in  = item.time_now;
               end
            end
            PH_FALLING: begin
               if (deb_done) begin
                  if (active) begin
                     phase_in = PH_PRESSED;
                     mark_in  = item.time_now;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_PRESSED: begin
               if (active) begin
                  // pin the hold time at long_time while held
                  if (elapsed >= cfg.long_time) begin
                     mark_in = item.time_now - cfg.long_time;
                     if (!long_marked_ff) begin
                        long_marked_in = 1'b1;
                        ev_pending_in  = 1'b1;
                        ev_long_in     = 1'b1;
                     end
                  end
               end else begin
                  if (!long_marked_ff && elapsed >= cfg.short_time) begin
                     ev_pending_in = 1'b1;
                     ev_long_in    = 1'b0;
                  end
                  saved_in = mark_ff;
                  mark_in  = item.time_now;
                  phase_in = PH_RISING;
               end
            end
            PH_RISING: begin
               if (deb_done) begin
                  if (!active) begin
                     phase_in = PH_IDLE;
                  end else begin
                     // bounce on release: restore the press start
                     phase_in = PH_PRESSED;
                     mark_in  = saved_ff;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         long_marked_ff <= 1'b0;
         ev_pending_ff  <= 1'b0;
         ev_long_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         long_marked_ff <= long_marked_in;
         ev_pending_ff  <= ev_pending_in;
         ev_long_ff     <= ev_long_in;
      end
   end

   // time marks
   always_ff @(posedge clock) begin
      if (fire) begin
         mark_ff  <= mark_in;
         saved_ff <= saved_in;
      end
   end

   // result seen after this item
   always_comb begin
      result.phase = phase_in;
      if (!ev_pending_in) begin
         result.event_code = EV_NONE;
      end else if (ev_long_in) begin
         result.event_code = EV_LONG;
      end else begin
         result.event_code = EV_SHORT;
      end
   end

   // a long event is raised only from the pressed phase
   a_long_from_pressed: assert property (@(posedge clock) disable iff (reset)
      fire && !long_marked_ff && long_marked_in |-> phase_ff == PH_PRESSED && ev_long_in)
      else $error("long mark set outside pressed phase");

   // a clear command drops the event and leaves the debouncer alone
   a_clear: assert property (@(posedge clock) disable iff (reset)
      fire && item.op == OP_CLEAR |=> !ev_pending_ff && $stable(phase_ff))
      else $error("clear command misbehaved");

   // the rising phase is entered only from pressed
   a_rising_entry: assert property (@(posedge clock) disable iff (reset)
      fire && phase_in == PH_RISING && phase_ff != PH_RISING |-> phase_ff == PH_PRESSED)
      else $error("rising phase entered from wrong phase");

endmodule

`default_nettype wire

// File: src/button_debounce_short_long_press_core.sv
// Top level of the button debouncer with short/long press detection.
// Depends on bdsl_pkg, bdsl_if, bdsl_csr and bdsl_core.
`default_nettype none

// Takes one item per clock on req_chan while the result side is not blocked
// (a sample tick with a 16-bit timestamp and pin level, or a clear command)
// and returns exactly one result per item on rsp_chan: the latched event code
// (none, short, long) and the debounce phase. An item is registered on arrival,
// and its result is registered once the result register is free. Configuration
// registers (rest_level, settle_time, short_time, long_time) sit at byte
// addresses 0, 4, 8, 12 and should be written only while no item is in flight;
// a zero written to long_time is stored as 65535.
module button_debounce_short_long_press_core
   import bdsl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   bdsl_req_if.sink                  req_chan,
   bdsl_rsp_if.source                rsp_chan,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [AddrWidth-1:0] paddr,
   input  wire logic [DataWidth-1:0] pwdata,
   output      logic [DataWidth-1:0] prdata,
   output      logic                 pready
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_vld_ff;
   result_type result, out_ff;
   logic       out_vld_ff;
   logic       adv;
   logic       req_xfer;

   bdsl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // advance the held item when the result register is free
   assign adv            = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || adv;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_xfer) begin
         in_vld_ff <= 1'b1;
      end else if (adv) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff.op        <= req_chan.op;
         item_ff.time_now  <= req_chan.time_now;
         item_ff.pin_level <= req_chan.pin_level;
      end
   end

   bdsl_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (adv),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid      = out_vld_ff;
   assign rsp_chan.event_code = out_ff.event_code;
   assign rsp_chan.phase      = out_ff.phase;

   // an advanced item always lands in the result register
   a_adv_lands: assert property (@(posedge clock) disable iff (reset)
      adv |=> out_vld_ff)
      else $error("advanced item lost");

   // a held item stays while the result side is blocked
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !adv |=> in_vld_ff && $stable(item_ff))
      else $error("held item dropped or changed");

   // a taken result with nothing behind it empties the result register
   a_out_drain: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && rsp_chan.ready && !adv |=> !out_vld_ff)
      else $error("result repeated after transfer");

endmodule

`default_nettype wire

// File: tb/button_debounce_short_long_press_core_tb.sv
// Self-checking testbench for button_debounce_short_long_press_core: random press
// sequences on the item channel, APB register writes between phases, result checks.
// Depends on bdsl_pkg, bdsl_if and the debouncer RTL.
`default_nettype none

module button_debounce_short_long_press_core_tb;
   import bdsl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_GAP      = 4;
   localparam int REPORT_CAP     = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 psel    = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite  = 1'b0;
   logic [AddrWidth-1:0] paddr   = '0;
   logic [DataWidth-1:0] pwdata  = '0;
   logic [DataWidth-1:0] prdata;
   logic                 pready;

   bdsl_req_if req_if ();
   bdsl_rsp_if rsp_if ();

   button_debounce_short_long_press_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #1 clock = ~clock;

   // pending stimulus and expected results
   item_type   press_item_q[$];
   result_type press_exp_q[$];
   item_type   drv_item;

   int mismatch_count = 0;
   int idle_pct       = 15;
   int jump_span      = 64;
   int items_made     = 0;
   int stall_cycles   = 0;
   logic [TimeWidth-1:0] tick = '0;

   // predictor state and register copy
   cfg_type              press_cfg;
   logic [1:0]           phase_q;
   logic [TimeWidth-1:0] mark_q;
   logic [TimeWidth-1:0] saved_mark_q;
   logic                 long_seen_q;
   logic                 pend_q;
   logic                 pend_long_q;

   task automatic report_mismatch(string msg);
      if (mismatch_count < REPORT_CAP) $display("ERROR at %0t ns: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic void reset_press_model();
      press_cfg.rest_level  = REST_RESET;
      press_cfg.settle_time = DEBOUNCE_RESET;
      press_cfg.short_time  = SHORT_RESET;
      press_cfg.long_time   = LONG_DEFAULT;
      phase_q      = PH_IDLE;
      mark_q       = '0;
      saved_mark_q = '0;
      long_seen_q  = 1'b0;
      pend_q       = 1'b0;
      pend_long_q  = 1'b0;
   endfunction

   // Advance the debouncer by one item and return the event and phase it reports.
   function automatic result_type predict_press(item_type it);
      logic                 active;
      logic [TimeWidth-1:0] span;
      result_type           res;
      active = (it.pin_level != press_cfg.rest_level);
      span   = it.time_now - mark_q;
      if (it.op == OP_CLEAR) begin
         pend_q = 1'b0;
      end else begin
         case (phase_q)
            PH_IDLE: begin
               long_seen_q = 1'b0;
               if (active) begin
                  phase_q = PH_FALLING;
                  mark_q  = it.time_now;
               end
            end
            PH_FALLING: begin
               if (span >= press_cfg.settle_time) begin
                  if (active) begin
                     phase_q = PH_PRESSED;
                     mark_q  = it.time_now;
                  end else begin
                     phase_q = PH_IDLE;
                  end
               end
            end
            PH_PRESSED: begin
               if (active) begin
                  // hold the elapsed time at long_time while held
                  if (span >= press_cfg.long_time) begin
                     mark_q = it.time_now - press_cfg.long_time;
                     if (!long_seen_q) begin
                        long_seen_q = 1'b1;
                        pend_q      = 1'b1;
                        pend_long_q = 1'b1;
                     end
                  end
               end else begin
                  if (!long_seen_q && span >= press_cfg.short_time) begin
                     pend_q      = 1'b1;
                     pend_long_q = 1'b0;
                  end
                  saved_mark_q = mark_q;
                  mark_q       = it.time_now;
                  phase_q      = PH_RISING;
               end
            end
            default: begin
               // a bounce on release returns to pressed with the press start
               if (span >= press_cfg.settle_time) begin
                  if (!active) begin
                     phase_q = PH_IDLE;
                  end else begin
                     phase_q = PH_PRESSED;
                     mark_q  = saved_mark_q;
                  end
               end
            end
         endcase
      end
      res.event_code = !pend_q ? EV_NONE : (pend_long_q ? EV_LONG : EV_SHORT);
      res.phase      = phase_q;
      return res;
   endfunction

   // Driver: predict on each transfer, then present the next queued item.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) press_exp_q.push_back(predict_press(drv_item));
         if (!req_if.valid || req_if.ready) begin
            if (press_item_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               drv_item            = press_item_q.pop_front();
               req_if.valid       <= 1'b1;
               req_if.op          <= drv_item.op;
               req_if.time_now    <= drv_item.time_now;
               req_if.pin_level   <= drv_item.pin_level;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer against the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (press_exp_q.size() == 0) begin
               report_mismatch("result transfer with no result expected");
            end else begin
               want = press_exp_q.pop_front();
               if (rsp_if.event_code !== want.event_code)
                  report_mismatch($sformatf("event_code %0d, expected %0d",
                                            rsp_if.event_code, want.event_code));
               if (rsp_if.phase !== want.phase)
                  report_mismatch($sformatf("phase %0d, expected %0d",
                                            rsp_if.phase, want.phase));
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", stall_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_sample(logic op, logic [TimeWidth-1:0] t, logic pin);
      item_type it;
      it.op        = op;
      it.time_now  = t;
      it.pin_level = pin;
      press_item_q.push_back(it);
      items_made++;
   endtask

   // Advance the timestamp, mostly in small steps, and queue one sample, sometimes after a clear command.
   task automatic push_tick(logic pin);
      int r;
      if ($urandom_range(99) < 5)
         push_sample(OP_CLEAR, TimeWidth'($urandom_range(65535)), 1'($urandom_range(1)));
      r = $urandom_range(99);
      if (r < 70)      tick = tick + TimeWidth'($urandom_range(1, 4));
      else if (r < 95) tick = tick + TimeWidth'($urandom_range(jump_span));
      else             tick = TimeWidth'($urandom_range(65535));
      push_sample(OP_SAMPLE, tick, pin);
   endtask

   // One press (rest, optional bounce, hold with glitches, optional bounce, rest), or a burst of random samples.
   task automatic push_episode();
      logic act;
      act = ~press_cfg.rest_level;
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 5))
            push_sample(OP_SAMPLE, TimeWidth'($urandom_range(65535)),
                        1'($urandom_range(1)));
      end else begin
         repeat ($urandom_range(1, 4)) push_tick(~act);
         if ($urandom_range(99) < 30) begin
            push_tick(act);
            push_tick(~act);
         end
         repeat ($urandom_range(1, 24)) push_tick(($urandom_range(99) < 8) ? ~act : act);
         if ($urandom_range(99) < 30) begin
            push_tick(~act);
            push_tick(act);
         end
         repeat ($urandom_range(1, 3)) push_tick(~act);
      end
   endtask

   // Wait until every item has gone out and every result has come back.
   task automatic wait_drain();
      do @(negedge clock);
      while (press_item_q.size() != 0 || req_if.valid || press_exp_q.size() != 0);
      repeat (DRAIN_GAP) @(negedge clock);
   endtask

   // APB write followed by a read back of the same register.
   task automatic csr_write(logic [1:0] idx, logic [DataWidth-1:0] value);
      logic [DataWidth-1:0] want;
      logic [DataWidth-1:0] got;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_REST:     press_cfg.rest_level  = value[0];
         REG_DEBOUNCE: press_cfg.settle_time = value[TimeWidth-1:0];
         REG_SHORT:    press_cfg.short_time  = value[TimeWidth-1:0];
         default:      press_cfg.long_time   = (value[TimeWidth-1:0] == '0) ?
                                               LONG_DEFAULT : value[TimeWidth-1:0];
      endcase
      case (idx)
         REG_REST:     want = DataWidth'(press_cfg.rest_level);
         REG_DEBOUNCE: want = DataWidth'(press_cfg.settle_time);
         REG_SHORT:    want = DataWidth'(press_cfg.short_time);
         default:      want = DataWidth'(press_cfg.long_time);
      endcase
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== want)
         report_mismatch($sformatf("register %0d read 0x%0h, expected 0x%0h", idx, got, want));
   endtask

   // Program all registers, then run random presses with a full drain halfway.
   task automatic run_phase(logic rest, int deb, int short_t, int long_t, int span,
                            int calm, int n_items);
      int target;
      csr_write(REG_REST, DataWidth'(rest));
      csr_write(REG_DEBOUNCE, deb);
      csr_write(REG_SHORT, short_t);
      csr_write(REG_LONG, long_t);
      jump_span = span;
      idle_pct  = calm ? 0 : 15;
      target = items_made + n_items / 2;
      while (items_made < target) push_episode();
      wait_drain();
      target = items_made + n_items - n_items / 2;
      while (items_made < target) push_episode();
      wait_drain();
   endtask

   initial begin
      req_if.valid     = 1'b0;
      req_if.op        = OP_SAMPLE;
      req_if.time_now  = '0;
      req_if.pin_level = 1'b0;
      rsp_if.ready     = 1'b0;
      reset_press_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: short press, release bounce, aborted press, timestamp wrap
      push_sample(OP_SAMPLE, 16'd0, 1'b1);
      push_sample(OP_SAMPLE, 16'd10, 1'b0);
      push_sample(OP_SAMPLE, 16'd20, 1'b0);
      push_sample(OP_SAMPLE, 16'd30, 1'b0);
      push_sample(OP_SAMPLE, 16'd100, 1'b1);
      push_sample(OP_SAMPLE, 16'd105, 1'b0);
      push_sample(OP_SAMPLE, 16'd125, 1'b0);
      push_sample(OP_SAMPLE, 16'd130, 1'b1);
      push_sample(OP_SAMPLE, 16'd150, 1'b1);
      push_sample(OP_CLEAR, 16'hffff, 1'b0);
      push_sample(OP_SAMPLE, 16'd200, 1'b0);
      push_sample(OP_SAMPLE, 16'd230, 1'b1);
      push_sample(OP_SAMPLE, 16'hfffa, 1'b0);
      push_sample(OP_SAMPLE, 16'd14, 1'b0);
      push_sample(OP_SAMPLE, 16'd20, 1'b1);
      push_sample(OP_SAMPLE, 16'hffff, 1'b1);
      wait_drain();

      // zero long_time reads back as the default; then long press held and overwritten
      csr_write(REG_LONG, 0);
      csr_write(REG_REST, 0);
      csr_write(REG_DEBOUNCE, 0);
      csr_write(REG_SHORT, 0);
      csr_write(REG_LONG, 5);
      push_sample(OP_SAMPLE, 16'd0, 1'b0);
      push_sample(OP_SAMPLE, 16'hffff, 1'b1);
      push_sample(OP_SAMPLE, 16'hffff, 1'b1);
      push_sample(OP_SAMPLE, 16'd4, 1'b1);
      push_sample(OP_SAMPLE, 16'd100, 1'b1);
      push_sample(OP_SAMPLE, 16'd101, 1'b0);
      push_sample(OP_SAMPLE, 16'd101, 1'b0);
      push_sample(OP_SAMPLE, 16'd102, 1'b1);
      push_sample(OP_SAMPLE, 16'd102, 1'b1);
      push_sample(OP_SAMPLE, 16'd102, 1'b0);
      push_sample(OP_CLEAR, 16'd0, 1'b1);
      wait_drain();

      // random presses over several settings, extremes included
      run_phase(1'b1, 20, 50, 65535, 64, 0, 260);
      run_phase(1'b0, 3, 10, 40, 40, 0, 260);
      run_phase(1'b1, 0, 0, 1, 8, 0, 260);
      run_phase(1'b0, 65535, 65535, 65535, 65535, 0, 200);
      run_phase(1'b1, 5, 20, 60, 40, 1, 300);
      run_phase(1'($urandom_range(1)), $urandom_range(12), $urandom_range(60),
                $urandom_range(1, 120), 64, 0, 260);
      run_phase(1'($urandom_range(1)), $urandom_range(12), $urandom_range(60),
                $urandom_range(1, 120), 64, 0, 260);

      wait_drain();
      if (press_exp_q.size() != 0) report_mismatch("results still expected at end of run");
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
src/bdsl_pkg.sv
src/bdsl_if.sv
src/bdsl_csr.sv
src/bdsl_core.sv
src/button_debounce_short_long_press_core.sv
tb/button_debounce_short_long_press_core_tb.sv
